### rtl/ayt_pkg.sv
// Shared constants and helpers for the ARGB to planar YUVA tile unit.
// Holds the fixed-point color coefficients, field widths and the clamp function.
// No dependencies.
`default_nettype none

package ayt_pkg;

	localparam int CHAN_W   = 8;
	localparam int COORD_W  = 13;
	localparam int STRIDE_W = 16;
	localparam int BASE_W   = 32;
	localparam int OFFS_W   = 12;
	localparam int SUM_W    = 27;
	localparam int FRAC_W   = 16;
	localparam int SHR_W    = SUM_W - FRAC_W;

	localparam int TILE_SIZE = 64;
	localparam int TILE_LOG2 = $clog2(TILE_SIZE);
	localparam int ROW_W     = OFFS_W - TILE_LOG2;

	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 80;

	localparam logic signed [SUM_W-1:0] COEF_YR = 27'sd19595;
	localparam logic signed [SUM_W-1:0] COEF_YG = 27'sd38470;
	localparam logic signed [SUM_W-1:0] COEF_YB = 27'sd7471;
	localparam logic signed [SUM_W-1:0] COEF_UR = -27'sd11071;
	localparam logic signed [SUM_W-1:0] COEF_UG = -27'sd21736;
	localparam logic signed [SUM_W-1:0] COEF_UB = 27'sd32807;
	localparam logic signed [SUM_W-1:0] COEF_VR = 27'sd32756;
	localparam logic signed [SUM_W-1:0] COEF_VG = -27'sd27429;
	localparam logic signed [SUM_W-1:0] COEF_VB = -27'sd5327;

	localparam logic signed [SHR_W-1:0] LUMA_BIAS = 11'sd128;
	localparam logic signed [SHR_W-1:0] S8_MAX    = 11'sd127;
	localparam logic signed [SHR_W-1:0] S8_MIN    = -11'sd128;

	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd16384;

	function automatic logic signed [CHAN_W-1:0] clamp_s8(input logic signed [SHR_W-1:0] v);
		logic signed [CHAN_W-1:0] r;
		if (v < S8_MIN) begin
			r = S8_MIN[CHAN_W-1:0];
		end else if (v > S8_MAX) begin
			r = S8_MAX[CHAN_W-1:0];
		end else begin
			r = v[CHAN_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [SUM_W-1:0] chan_ext(input logic [CHAN_W-1:0] c);
		return $signed({{(SUM_W-CHAN_W){1'b0}}, c});
	endfunction

endpackage

`default_nettype wire

### rtl/argb_to_planar_yuva_tile_unit.sv
// Top level of the ARGB to planar YUVA tile unit: a three-stage color and address pipeline.
// Depends on ayt_pkg for coefficients, widths and the clamp function.
`default_nettype none

// An accepted input beat passes through the stage 1, stage 2 and stage 3 registers to the output.
// One beat per cycle unless m_tready stalls; each stage holds alone, so bubbles close up.
// Stage 1 holds the nine channel products and the tile row multiply, stage 2 the
// shifted sums and addresses, stage 3 the clamped bytes as the output register.
// Reset clears all valid bits and loads dest_stride with 16384.
module argb_to_planar_yuva_tile_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [ayt_pkg::STRIDE_W-1:0]     cfg_data,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// pixel_argb[31:0], pixel_x[44:32], pixel_y[57:45], tile_x[70:58], tile_y[83:71]
	input  wire logic [ayt_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// tile_base[31:0], plane_offset[43:32], luma[51:44], chroma_u[59:52],
	// chroma_v[67:60], alpha_out[75:68]
	output logic [ayt_pkg::OUT_DATA_W-1:0]        m_tdata
);

	localparam int CW = ayt_pkg::CHAN_W;
	localparam int KW = ayt_pkg::COORD_W;
	localparam int SW = ayt_pkg::SUM_W;
	localparam int HW = ayt_pkg::SHR_W;
	localparam int MW = KW + CW;

	logic [ayt_pkg::STRIDE_W-1:0] dest_stride_q;

	logic [CW-1:0] in_a, in_r, in_g, in_b;
	logic [KW-1:0] in_px, in_py, in_tx, in_ty;

	logic en1, en2, en3;
	logic vld_s1, vld_s2, vld_s3;

	logic signed [SW-1:0] p_yr_s1, p_yg_s1, p_yb_s1;
	logic signed [SW-1:0] p_ur_s1, p_ug_s1, p_ub_s1;
	logic signed [SW-1:0] p_vr_s1, p_vg_s1, p_vb_s1;
	logic [MW-1:0]               tmul_s1;
	logic [KW-1:0]               tx_s1;
	logic [ayt_pkg::ROW_W-1:0]   dy_s1;
	logic [ayt_pkg::OFFS_W-1:0]  dx_s1;
	logic [CW-1:0]               a_s1;

	logic signed [SW-1:0] ysum, usum, vsum;
	logic signed [HW-1:0] y_s2, u_s2, v_s2;
	logic [ayt_pkg::BASE_W-1:0]  base_s2;
	logic [ayt_pkg::OFFS_W-1:0]  offs_s2;
	logic [CW-1:0]               a_s2;

	logic [CW-1:0]               luma_s3, u_s3, v_s3, a_s3;
	logic [ayt_pkg::BASE_W-1:0]  base_s3;
	logic [ayt_pkg::OFFS_W-1:0]  offs_s3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_stride_q <= ayt_pkg::STRIDE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dest_stride_q <= cfg_data;
		end
	end

	assign in_b  = s_tdata[7:0];
	assign in_g  = s_tdata[15:8];
	assign in_r  = s_tdata[23:16];
	assign in_a  = s_tdata[31:24];
	assign in_px = s_tdata[44:32];
	assign in_py = s_tdata[57:45];
	assign in_tx = s_tdata[70:58];
	assign in_ty = s_tdata[83:71];

	assign en3      = !vld_s3 || m_tready;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1) begin
				vld_s1 <= s_tvalid;
			end
			if (en2) begin
				vld_s2 <= vld_s1;
			end
			if (en3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && s_tvalid) begin
			p_yr_s1 <= ayt_pkg::chan_ext(in_r) * ayt_pkg::COEF_YR;
			p_yg_s1 <= ayt_pkg::chan_ext(in_g) * ayt_pkg::COEF_YG;
			p_yb_s1 <= ayt_pkg::chan_ext(in_b) * ayt_pkg::COEF_YB;
			p_ur_s1 <= ayt_pkg::chan_ext(in_r) * ayt_pkg::COEF_UR;
			p_ug_s1 <= ayt_pkg::chan_ext(in_g) * ayt_pkg::COEF_UG;
			p_ub_s1 <= ayt_pkg::chan_ext(in_b) * ayt_pkg::COEF_UB;
			p_vr_s1 <= ayt_pkg::chan_ext(in_r) * ayt_pkg::COEF_VR;
			p_vg_s1 <= ayt_pkg::chan_ext(in_g) * ayt_pkg::COEF_VG;
			p_vb_s1 <= ayt_pkg::chan_ext(in_b) * ayt_pkg::COEF_VB;
			tmul_s1 <= MW'(in_ty) * MW'(dest_stride_q[ayt_pkg::STRIDE_W-1:CW]);
			tx_s1   <= in_tx;
			dy_s1   <= ayt_pkg::ROW_W'(in_py - in_ty);
			dx_s1   <= ayt_pkg::OFFS_W'(in_px - in_tx);
			a_s1    <= in_a;
		end
	end

	assign ysum = p_yr_s1 + p_yg_s1 + p_yb_s1;
	assign usum = p_ur_s1 + p_ug_s1 + p_ub_s1;
	assign vsum = p_vr_s1 + p_vg_s1 + p_vb_s1;

	always_ff @(posedge clk) begin
		if (en2 && vld_s1) begin
			y_s2    <= HW'(ysum >>> ayt_pkg::FRAC_W);
			u_s2    <= HW'(usum >>> ayt_pkg::FRAC_W);
			v_s2    <= HW'(vsum >>> ayt_pkg::FRAC_W);
			base_s2 <= ayt_pkg::BASE_W'({tmul_s1, 8'd0}) + ayt_pkg::BASE_W'({tx_s1, 8'd0});
			offs_s2 <= {dy_s1, {ayt_pkg::TILE_LOG2{1'b0}}} + dx_s1;
			a_s2    <= a_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && vld_s2) begin
			luma_s3 <= ayt_pkg::clamp_s8(y_s2 - ayt_pkg::LUMA_BIAS);
			u_s3    <= ayt_pkg::clamp_s8(u_s2);
			v_s3    <= ayt_pkg::clamp_s8(v_s2);
			base_s3 <= base_s2;
			offs_s3 <= offs_s2;
			a_s3    <= a_s2;
		end
	end

	assign m_tvalid = vld_s3;
	assign m_tdata  = {4'd0, a_s3, v_s3, u_s3, luma_s3, offs_s3, base_s3};

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_s1)
		else $error("Accepted beat did not reach stage 1.");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !en2) |=> (vld_s1 && $stable(tmul_s1) && $stable(p_yr_s1)))
		else $error("Stage 1 changed while stalled.");

	a_luma_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (y_s2 >= 11'sd0 && y_s2 <= 11'sd255))
		else $error("Shifted luma sum left 0 to 255.");

	a_out_after_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && en3) |=> m_tvalid)
		else $error("Stage 2 beat was lost on its way to the output.");

endmodule

`default_nettype wire

### verif/argb_to_planar_yuva_tile_unit_tb.sv
// Self-checking testbench for argb_to_planar_yuva_tile_unit: random and directed pixel beats,
// random idling on both streams, stride writes between phases, in-order result checking.
// Depends on ayt_pkg for port widths and on the RTL of the unit.

module argb_to_planar_yuva_tile_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 250000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 200;

	localparam int K_YR = 19595;
	localparam int K_YG = 38470;
	localparam int K_YB = 7471;
	localparam int K_UR = -11071;
	localparam int K_UG = -21736;
	localparam int K_UB = 32807;
	localparam int K_VR = 32756;
	localparam int K_VG = -27429;
	localparam int K_VB = -5327;
	localparam int LUMA_OFS = 128;
	localparam int TILE_DIM = 64;

	typedef struct {
		logic [31:0] argb;
		logic [12:0] px;
		logic [12:0] py;
		logic [12:0] tx;
		logic [12:0] ty;
		int unsigned gap;
	} pixel_t;

	typedef struct {
		logic [31:0]       base;
		logic [11:0]       offs;
		logic signed [7:0] luma;
		logic signed [7:0] cu;
		logic signed [7:0] cv;
		logic [7:0]        alpha;
	} yuva_t;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [ayt_pkg::STRIDE_W-1:0]     cfg_data;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [ayt_pkg::IN_DATA_W-1:0]    s_tdata;
	logic                             m_tvalid;
	logic                             m_tready;
	logic [ayt_pkg::OUT_DATA_W-1:0]   m_tdata;

	pixel_t      pixel_q[$];
	yuva_t       yuva_due_q[$];
	yuva_t       mon_want;
	logic [15:0] stride_model;
	bit          src_calm;
	bit          sink_calm;
	int unsigned sink_wait;
	int unsigned sink_beats;
	int unsigned hold_left;
	bit          hold_arm;
	int unsigned cycle_cnt;
	int          err_cnt;

	argb_to_planar_yuva_tile_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic signed [7:0] sat8(int v);
		if (v < -128) begin
			return -8'sd128;
		end
		if (v > 127) begin
			return 8'sd127;
		end
		return v[7:0];
	endfunction

	function automatic yuva_t convert_pixel(logic [ayt_pkg::IN_DATA_W-1:0] d,
			logic [15:0] stride);
		int r;
		int g;
		int b;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] tx;
		logic [31:0] ty;
		logic [31:0] offs;
		yuva_t o;
		r = int'(d[23:16]);
		g = int'(d[15:8]);
		b = int'(d[7:0]);
		px = {19'b0, d[44:32]};
		py = {19'b0, d[57:45]};
		tx = {19'b0, d[70:58]};
		ty = {19'b0, d[83:71]};
		o.luma = sat8(((r * K_YR + g * K_YG + b * K_YB) >>> 16) - LUMA_OFS);
		o.cu = sat8((r * K_UR + g * K_UG + b * K_UB) >>> 16);
		o.cv = sat8((r * K_VR + g * K_VG + b * K_VB) >>> 16);
		o.alpha = d[31:24];
		o.base = (ty << 8) * {24'b0, stride[15:8]} + (tx << 8);
		offs = (py - ty) * TILE_DIM + (px - tx);
		o.offs = offs[11:0];
		return o;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			err_cnt++;
			if (err_cnt <= 10) begin
				$display("mismatch in %s: expected %h, got %h", name, want, got);
			end
		end
	endtask

	task automatic queue_pixel(logic [31:0] argb, logic [12:0] px, logic [12:0] py,
			logic [12:0] tx, logic [12:0] ty);
		pixel_t p;
		p.argb = argb;
		p.px = px;
		p.py = py;
		p.tx = tx;
		p.ty = ty;
		p.gap = src_calm ? 0 : $urandom_range(0, 10);
		pixel_q.push_back(p);
	endtask

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 5))
			0: begin
				return 8'h00;
			end
			1: begin
				return 8'hff;
			end
			default: begin
				return 8'($urandom);
			end
		endcase
	endfunction

	task automatic add_random(int unsigned n, bit steady);
		logic [31:0] argb;
		logic [12:0] tx;
		logic [12:0] ty;
		for (int unsigned i = 0; i < n; i++) begin
			if (i % 40 == 0) begin
				src_calm = steady || ($urandom_range(0, 3) == 0);
			end
			argb = $urandom;
			if ($urandom_range(0, 3) == 0) begin
				argb = {rand_chan(), rand_chan(), rand_chan(), rand_chan()};
			end
			if ($urandom_range(0, 4) != 0) begin
				tx = 13'($urandom_range(0, 127)) << 6;
				ty = 13'($urandom_range(0, 127)) << 6;
				queue_pixel(argb, tx + 13'($urandom_range(0, 63)),
					ty + 13'($urandom_range(0, 63)), tx, ty);
			end else begin
				queue_pixel(argb, 13'($urandom), 13'($urandom), 13'($urandom),
					13'($urandom));
			end
		end
	endtask

	task automatic settle();
		do begin
			@(posedge clk);
		end while (pixel_q.size() != 0 || s_tvalid || yuva_due_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_stride(logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		stride_model = val;
	endtask

	always @(posedge clk) begin
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (pixel_q.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (pixel_q[0].gap != 0) begin
				pixel_q[0].gap--;
				s_tvalid <= 1'b0;
			end else begin
				s_tdata <= {4'b0, pixel_q[0].ty, pixel_q[0].tx, pixel_q[0].py,
					pixel_q[0].px, pixel_q[0].argb};
				s_tvalid <= 1'b1;
				void'(pixel_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end else if (hold_arm) begin
				hold_left <= HOLD_CYCLES;
				hold_arm <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				sink_beats++;
				if (sink_beats % 50 == 0) begin
					sink_calm = ($urandom_range(0, 2) == 0);
				end
				sink_wait = sink_calm ? 0 : $urandom_range(0, 10);
			end else if (sink_wait != 0) begin
				sink_wait--;
			end
			m_tready <= (hold_left == 0) && (sink_wait == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (yuva_due_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10) begin
						$display("unexpected output beat %h", m_tdata);
					end
				end else begin
					mon_want = yuva_due_q.pop_front();
					check_field("tile_base", mon_want.base, m_tdata[31:0]);
					check_field("plane_offset", {20'b0, mon_want.offs}, {20'b0, m_tdata[43:32]});
					check_field("luma", {24'b0, mon_want.luma}, {24'b0, m_tdata[51:44]});
					check_field("chroma_u", {24'b0, mon_want.cu}, {24'b0, m_tdata[59:52]});
					check_field("chroma_v", {24'b0, mon_want.cv}, {24'b0, m_tdata[67:60]});
					check_field("alpha_out", {24'b0, mon_want.alpha}, {24'b0, m_tdata[75:68]});
				end
			end
			if (s_tvalid && s_tready) begin
				yuva_due_q.push_back(convert_pixel(s_tdata, stride_model));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("argb_to_planar_yuva_tile_unit_tb: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		stride_model = 16'd16384;
		src_calm = 1'b0;
		sink_calm = 1'b0;
		sink_wait = 0;
		sink_beats = 0;
		hold_left = 0;
		hold_arm = 1'b0;
		cycle_cnt = 0;
		err_cnt = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		queue_pixel(32'h0000_0000, 13'd0, 13'd0, 13'd0, 13'd0);
		queue_pixel(32'hffff_ffff, 13'd8191, 13'd8191, 13'd8191, 13'd8191);
		queue_pixel(32'h00ff_0000, 13'd63, 13'd63, 13'd0, 13'd0);
		queue_pixel(32'h0000_ff00, 13'd64, 13'd70, 13'd64, 13'd64);
		queue_pixel(32'h0000_00ff, 13'd130, 13'd200, 13'd128, 13'd192);
		queue_pixel(32'hff00_0000, 13'd1, 13'd2, 13'd0, 13'd0);
		queue_pixel(32'h8080_8080, 13'd4100, 13'd4160, 13'd4096, 13'd4160);
		queue_pixel(32'h00ff_ff00, 13'd300, 13'd310, 13'd256, 13'd256);
		queue_pixel(32'h00ff_00ff, 13'd520, 13'd600, 13'd512, 13'd576);
		queue_pixel(32'h0000_ffff, 13'd1000, 13'd1000, 13'd960, 13'd960);
		queue_pixel(32'h7f01_0203, 13'd5, 13'd5, 13'd0, 13'd0);
		queue_pixel(32'haa55_5555, 13'd2000, 13'd3000, 13'd1984, 13'd2944);
		queue_pixel(32'h55aa_aaaa, 13'd8191, 13'd8191, 13'd8128, 13'd8128);
		// Pixel left of and above its tile: the offset wraps.
		queue_pixel(32'h1234_5678, 13'd0, 13'd0, 13'd64, 13'd64);
		queue_pixel(32'h80ff_0000, 13'd8191, 13'd0, 13'd0, 13'd8191);
		// Tile origin off the 64 grid is taken as given.
		queue_pixel(32'h4000_ff80, 13'd10, 13'd7, 13'd5, 13'd3);
		queue_pixel(32'h0101_0101, 13'd4095, 13'd2047, 13'd4033, 13'd1985);
		queue_pixel(32'hfe00_00ff, 13'd8000, 13'd100, 13'd8191, 13'd8191);
		add_random(150, 1'b0);
		settle();

		write_stride(16'd0);
		add_random(180, 1'b0);
		settle();
		write_stride(16'hffff);
		add_random(180, 1'b0);
		settle();
		write_stride(16'd255);
		add_random(180, 1'b0);
		settle();
		write_stride(16'd256);
		add_random(180, 1'b0);
		settle();
		write_stride(16'($urandom));
		add_random(180, 1'b0);
		settle();
		write_stride(16'($urandom));
		add_random(180, 1'b0);
		settle();

		// The sink stops for a long stretch while the source keeps sending back to back.
		write_stride(16'd16383);
		@(negedge clk);
		hold_arm = 1'b1;
		add_random(260, 1'b1);
		settle();

		if (err_cnt == 0) begin
			$display("argb_to_planar_yuva_tile_unit_tb: done, clean");
		end else begin
			$display("argb_to_planar_yuva_tile_unit_tb: done, errors");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/ayt_pkg.sv
rtl/argb_to_planar_yuva_tile_unit.sv
verif/argb_to_planar_yuva_tile_unit_tb.sv
